/* rtl/cst_pkg.sv */
// Shared types and constants of the character stream tokenizer.
// No dependencies.
package cst_pkg;

    localparam int RUN_DEPTH = 3;
    localparam int LINE_OUT_W = 24;

    typedef enum logic [2:0] {
        K_INT     = 3'd0,
        K_DOUBLE  = 3'd1,
        K_PDOUBLE = 3'd2,
        K_IDENT   = 3'd3,
        K_OPER    = 3'd4,
        K_STRING  = 3'd5,
        K_OPENSTR = 3'd6,   // open string; reported as unfinished string
        K_NONE    = 3'd7
    } t_kind;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    typedef struct packed {
        logic                  is_token_end;
        logic [7:0]            char_out;
        t_kind                 token_kind;
        logic [LINE_OUT_W-1:0] line_number;
        logic                  last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0]                  count;
        t_result [RUN_DEPTH-1:0]     slot;
    } t_run;

endpackage

/* rtl/cst_decode.sv */
// Per-item decode: character class, next token kind and the result run.
// Depends on cst_pkg.
module cst_decode (
    input  logic                          i_flush,
    input  logic [7:0]                    i_char,
    input  cst_pkg::t_kind                i_kind,
    input  logic [cst_pkg::LINE_OUT_W-1:0] i_line,
    output cst_pkg::t_kind                o_kind,
    output logic                          o_line_inc,
    output cst_pkg::t_run                 o_run
);
    import cst_pkg::*;

    function automatic logic is_operator(input logic [7:0] c);
        case (c) inside
            // { } ( ) , ; : * / + - = > [ ] <
            8'h7B, 8'h7D, 8'h28, 8'h29, 8'h2C, 8'h3B, 8'h3A, 8'h2A,
            8'h2F, 8'h2B, 8'h2D, 8'h3D, 8'h3E, 8'h5B, 8'h5D, 8'h3C: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    logic  e_close;
    logic  e_app;
    logic  e_post;
    t_kind post_kind;
    logic  is_open;

    assign is_open = (i_kind != K_NONE);

    always_comb begin
        e_close    = 1'b0;
        e_app      = 1'b0;
        e_post     = 1'b0;
        post_kind  = K_OPER;
        o_kind     = i_kind;
        o_line_inc = 1'b0;
        if (i_flush) begin
            e_close = is_open;
            o_kind  = K_NONE;
        end else if (i_char inside {[CH_0:CH_9]}) begin
            e_app = 1'b1;
            case (i_kind)
                K_NONE:    o_kind = K_INT;
                K_PDOUBLE: o_kind = K_DOUBLE;
                K_IDENT: begin
                    e_close = 1'b1;
                    o_kind  = K_INT;
                end
                default:   o_kind = i_kind;
            endcase
        end else if (i_char == CH_DOT) begin
            e_app = 1'b1;
            if (i_kind == K_INT) begin
                o_kind = K_PDOUBLE;
            end else if (i_kind == K_NONE) begin
                e_post = 1'b1;
            end
        end else if (is_operator(i_char)) begin
            e_app = 1'b1;
            if (i_kind != K_OPENSTR) begin
                e_close = is_open;
                e_post  = 1'b1;
                o_kind  = K_NONE;
            end
        end else if (i_char == CH_QUOTE) begin
            if (i_kind == K_NONE) begin
                e_app  = 1'b1;
                o_kind = K_OPENSTR;
            end else if (i_kind == K_OPENSTR) begin
                e_app     = 1'b1;
                e_post    = 1'b1;
                post_kind = K_STRING;
                o_kind    = K_NONE;
            end
        end else if (i_char == CH_NL) begin
            e_close    = is_open;
            o_kind     = K_NONE;
            o_line_inc = 1'b1;
        end else if (i_char == CH_SPACE) begin
            e_app = is_open;
            if (i_kind != K_OPENSTR) begin
                e_post    = is_open;
                post_kind = i_kind;
                o_kind    = K_NONE;
            end
        end else begin
            e_app = 1'b1;
            if (i_kind == K_NONE) begin
                o_kind = K_IDENT;
            end else if (i_kind == K_INT || i_kind == K_DOUBLE) begin
                e_close = 1'b1;
                o_kind  = K_IDENT;
            end
        end
    end

    always_comb begin
        t_result    c_close;
        t_result    c_app;
        t_result    c_post;
        logic [1:0] idx;
        c_close = '{is_token_end: 1'b1, char_out: 8'd0, token_kind: i_kind,
                    line_number: i_line, last_of_run: 1'b0};
        c_app   = '{is_token_end: 1'b0, char_out: i_char, token_kind: K_INT,
                    line_number: '0, last_of_run: 1'b0};
        c_post  = '{is_token_end: 1'b1, char_out: 8'd0, token_kind: post_kind,
                    line_number: i_line, last_of_run: 1'b0};
        o_run = '0;
        idx   = 2'd0;
        if (e_close) begin
            o_run.slot[idx] = c_close;
            idx = idx + 2'd1;
        end
        if (e_app) begin
            o_run.slot[idx] = c_app;
            idx = idx + 2'd1;
        end
        if (e_post) begin
            o_run.slot[idx] = c_post;
            idx = idx + 2'd1;
        end
        o_run.count = idx;
        if (idx != 2'd0) begin
            o_run.slot[idx - 2'd1].last_of_run = 1'b1;
        end
    end

endmodule

/* rtl/cst_run_buf.sv */
// Result register: holds the run of one item and sends one result per cycle while the receiver is ready.
// Depends on cst_pkg.
module cst_run_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cst_pkg::t_run    i_run,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output cst_pkg::t_result o_result
);
    import cst_pkg::*;

    t_result [RUN_DEPTH-1:0] r_slot;
    t_result [RUN_DEPTH-1:0] n_slot;
    logic [1:0]              r_cnt;
    logic [1:0]              n_cnt;
    logic                    take;

    assign o_valid  = (r_cnt != 2'd0);
    assign take     = o_valid && i_ready;
    assign o_free   = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);
    assign o_result = r_slot[0];

    always_comb begin
        n_slot = r_slot;
        n_cnt  = r_cnt;
        if (i_load) begin
            n_slot = i_run.slot;
            n_cnt  = i_run.count;
        end else if (take) begin
            n_slot[0] = r_slot[1];
            n_slot[1] = r_slot[2];
            n_cnt     = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("run loaded while results remain");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(r_slot[0]))
        else $error("stalled result changed");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !r_slot[0].last_of_run |-> r_cnt > 2'd1)
        else $error("run ends without last mark");

endmodule

/* rtl/char_stream_tokenizer.sv */
// Character stream tokenizer top level: input register, token state,
// line counter, decode and result register. Depends on cst_pkg,
// cst_decode and cst_run_buf.
//
// channel   dir  handshake                payload
// input     in   i_valid / o_in_ready     i_flush, i_char_in
// result    out  o_valid / i_out_ready    o_is_token_end, o_char_out, o_token_kind,
//                                         o_line_number, o_last_of_run
// config    in   i_cfg_we                 i_cfg_data (first_line)
//
// An item passes the input register, is decoded against the token state and
// drops its run of zero to three results into the result register.
// One item per cycle while runs hold at most one result and the receiver is ready;
// a longer run stalls the next item in the input register till the run is sent.
// An accepted item goes through the input register, then the result register.
// Reset (synchronous, active low) closes any token and loads line 1.
// A config write loads the line counter with first_line, clamped.
module char_stream_tokenizer #(
    parameter int LINE_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_in_ready,
    input  logic        i_flush,
    input  logic [7:0]  i_char_in,
    output logic        o_valid,
    input  logic        i_out_ready,
    output logic        o_is_token_end,
    output logic [7:0]  o_char_out,
    output logic [2:0]  o_token_kind,
    output logic [23:0] o_line_number,
    output logic        o_last_of_run,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_data
);
    import cst_pkg::*;

    localparam logic [63:0] LINE_MAX64 = (64'd1 << LINE_BITS) - 64'd1;
    localparam logic [LINE_BITS-1:0] LINE_MAX = LINE_MAX64[LINE_BITS-1:0];

    logic                  r_iv;
    logic                  r_flush;
    logic [7:0]            r_char;
    t_kind                 r_kind;
    t_kind                 n_kind;
    logic [LINE_BITS-1:0]  r_line;
    logic [LINE_BITS-1:0]  n_line;
    logic                  line_inc;
    logic                  buf_free;
    logic                  move;
    logic [63:0]           line_ext;
    logic [63:0]           cfg_ext;
    t_run                  run;
    t_result               res;

    assign move       = r_iv && buf_free;
    assign o_in_ready = !r_iv || move;
    assign line_ext   = 64'(r_line);
    assign cfg_ext    = 64'(i_cfg_data);

    cst_decode u_decode (
        .i_flush    (r_flush),
        .i_char     (r_char),
        .i_kind     (r_kind),
        .i_line     (line_ext[LINE_OUT_W-1:0]),
        .o_kind     (n_kind),
        .o_line_inc (line_inc),
        .o_run      (run)
    );

    cst_run_buf u_run_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (move),
        .i_run    (run),
        .o_free   (buf_free),
        .o_valid  (o_valid),
        .i_ready  (i_out_ready),
        .o_result (res)
    );

    assign o_is_token_end = res.is_token_end;
    assign o_char_out     = res.char_out;
    assign o_token_kind   = res.token_kind;
    assign o_line_number  = res.line_number;
    assign o_last_of_run  = res.last_of_run;

    always_comb begin
        n_line = r_line;
        if (i_cfg_we) begin
            n_line = (cfg_ext > LINE_MAX64) ? LINE_MAX : cfg_ext[LINE_BITS-1:0];
        end else if (move && line_inc && (r_line != LINE_MAX)) begin
            n_line = r_line + LINE_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_in_ready) begin
            r_flush <= i_flush;
            r_char  <= i_char_in;
        end
        if (!i_rst_n) begin
            r_iv   <= 1'b0;
            r_kind <= K_NONE;
            r_line <= LINE_BITS'(1);
        end else begin
            if (o_in_ready) begin
                r_iv <= i_valid;
            end
            if (move) begin
                r_kind <= n_kind;
            end
            r_line <= n_line;
        end
    end

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iv && !move |=> r_iv && $stable(r_char) && $stable(r_flush))
        else $error("input register lost a stalled item");
    a_kind_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !move |=> $stable(r_kind))
        else $error("token state changed without an item");
    a_line_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_cfg_we) && $past(i_rst_n) && $past(r_line) == LINE_MAX
        |-> r_line == LINE_MAX)
        else $error("line counter wrapped");

endmodule

/* verif/char_stream_tokenizer_checker.sv */
// Scoreboard for the character stream tokenizer: follows the token state and
// line counter, predicts each item's run of results and checks them in order.
// Depends on cst_pkg.
`timescale 1ns / 1ps
module char_stream_tokenizer_checker #(
    parameter int LINE_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_ready,
    input  logic        i_flush,
    input  logic [7:0]  i_char_in,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_is_token_end,
    input  logic [7:0]  i_char_out,
    input  logic [2:0]  i_token_kind,
    input  logic [23:0] i_line_number,
    input  logic        i_last_of_run,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import cst_pkg::*;

    localparam longint unsigned LINE_LIMIT = (64'd1 << LINE_BITS) - 64'd1;

    t_result         token_results_q[$];
    t_kind           open_kind = K_NONE;
    longint unsigned line_count = 1;
    int              fail_total = 0;

    function automatic bit is_operator(logic [7:0] ch);
        case (ch)
            "{", "}", "(", ")", ",", ";", ":", "*",
            "/", "+", "-", "=", ">", "[", "]", "<": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic add_char(logic [7:0] ch);
        t_result r;
        r              = '0;
        r.char_out     = ch;
        r.token_kind   = K_INT;
        token_results_q = {token_results_q, r};
    endtask

    task automatic add_end(t_kind kind);
        t_result r;
        r              = '0;
        r.is_token_end = 1'b1;
        r.token_kind   = kind;
        r.line_number  = line_count[LINE_OUT_W-1:0];
        token_results_q = {token_results_q, r};
    endtask

    // An open string is reported as unfinished: same code.
    task automatic close_token();
        if (open_kind != K_NONE) begin
            add_end(open_kind);
        end
        open_kind = K_NONE;
    endtask

    task automatic lone_operator(logic [7:0] ch);
        close_token();
        add_char(ch);
        add_end(K_OPER);
    endtask

    task automatic tokenize(logic flush, logic [7:0] ch);
        int first_new;
        first_new = token_results_q.size();
        if (flush) begin
            close_token();
        end else if (ch >= CH_0 && ch <= CH_9) begin
            if (open_kind == K_IDENT) begin
                close_token();
            end
            if (open_kind == K_NONE) begin
                open_kind = K_INT;
            end else if (open_kind == K_PDOUBLE) begin
                open_kind = K_DOUBLE;
            end
            add_char(ch);
        end else if (ch == CH_DOT) begin
            if (open_kind == K_INT) begin
                open_kind = K_PDOUBLE;
                add_char(ch);
            end else if (open_kind == K_NONE) begin
                lone_operator(ch);
            end else begin
                add_char(ch);
            end
        end else if (is_operator(ch)) begin
            if (open_kind == K_OPENSTR) begin
                add_char(ch);
            end else begin
                lone_operator(ch);
            end
        end else if (ch == CH_QUOTE) begin
            if (open_kind == K_NONE) begin
                open_kind = K_OPENSTR;
                add_char(ch);
            end else if (open_kind == K_OPENSTR) begin
                add_char(ch);
                add_end(K_STRING);
                open_kind = K_NONE;
            end
        end else if (ch == CH_NL) begin
            close_token();
            if (line_count < LINE_LIMIT) begin
                line_count++;
            end
        end else if (ch == CH_SPACE) begin
            if (open_kind != K_NONE) begin
                add_char(ch);
            end
            if (open_kind != K_OPENSTR) begin
                close_token();
            end
        end else begin
            if (open_kind == K_NONE || open_kind == K_INT || open_kind == K_DOUBLE) begin
                close_token();
                open_kind = K_IDENT;
            end
            add_char(ch);
        end
        if (token_results_q.size() > first_new) begin
            token_results_q[token_results_q.size() - 1].last_of_run = 1'b1;
        end
    endtask

    function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            token_results_q.delete();
            open_kind  = K_NONE;
            line_count = 1;
        end else begin
            if (i_cfg_we) begin
                line_count = (64'(i_cfg_data) > LINE_LIMIT) ? LINE_LIMIT : 64'(i_cfg_data);
            end
            if (i_valid && i_in_ready) begin
                tokenize(i_flush, i_char_in);
            end
            if (i_out_valid && i_out_ready) begin
                if (token_results_q.size() == 0) begin
                    $error("result item with none expected");
                    fail_total++;
                end else begin
                    want = token_results_q.pop_front();
                    fail_total += field_diff("is_token_end", 32'(want.is_token_end),
                                             32'(i_is_token_end));
                    fail_total += field_diff("char_out", 32'(want.char_out), 32'(i_char_out));
                    fail_total += field_diff("token_kind", 32'(want.token_kind),
                                             32'(i_token_kind));
                    fail_total += field_diff("line_number", 32'(want.line_number),
                                             32'(i_line_number));
                    fail_total += field_diff("last_of_run", 32'(want.last_of_run),
                                             32'(i_last_of_run));
                end
            end
        end
        o_pending    <= token_results_q.size();
        o_fail_count <= fail_total;
    end

endmodule

/* verif/char_stream_tokenizer_test.sv */
// Testbench top for the character stream tokenizer: clock, reset, character
// stimulus, receiver back-pressure, watchdog and verdict.
// Depends on cst_pkg, char_stream_tokenizer and char_stream_tokenizer_checker.
`timescale 1ns / 1ps
module char_stream_tokenizer_test;
    import cst_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 100;
    localparam int PHASE_ITEMS    = 86;
    localparam int N_PHASES       = 5;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_in_ready;
    logic        i_flush     = 1'b0;
    logic [7:0]  i_char_in   = '0;
    logic        o_valid;
    logic        i_out_ready = 1'b0;
    logic        o_is_token_end;
    logic [7:0]  o_char_out;
    logic [2:0]  o_token_kind;
    logic [23:0] o_line_number;
    logic        o_last_of_run;
    logic        i_cfg_we    = 1'b0;
    logic [23:0] i_cfg_data  = '0;

    int fail_count;
    int pending;
    int items_sent   = 0;
    bit tx_idle_on   = 1'b0;
    bit rx_idle_on   = 1'b0;
    int hold_req     = 0;
    int hold_done    = 0;
    int rx_wait      = 0;
    int quiet_cycles = 0;

    logic [7:0] op_chars [16] = '{"{", "}", "(", ")", ",", ";", ":", "*",
                                  "/", "+", "-", "=", ">", "[", "]", "<"};

    always #5 i_clk = ~i_clk;

    char_stream_tokenizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_in_ready     (o_in_ready),
        .i_flush        (i_flush),
        .i_char_in      (i_char_in),
        .o_valid        (o_valid),
        .i_out_ready    (i_out_ready),
        .o_is_token_end (o_is_token_end),
        .o_char_out     (o_char_out),
        .o_token_kind   (o_token_kind),
        .o_line_number  (o_line_number),
        .o_last_of_run  (o_last_of_run),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    char_stream_tokenizer_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_in_ready     (o_in_ready),
        .i_flush        (i_flush),
        .i_char_in      (i_char_in),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_out_ready),
        .i_is_token_end (o_is_token_end),
        .i_char_out     (o_char_out),
        .i_token_kind   (o_token_kind),
        .i_line_number  (o_line_number),
        .i_last_of_run  (o_last_of_run),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Receiver: random stall bursts, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_req != hold_done) begin
            hold_done   <= hold_req;
            rx_wait     <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait     <= rx_wait - 1;
            i_out_ready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rx_wait     <= $urandom_range(0, 9);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_in_ready) || (o_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("char_stream_tokenizer_test: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] digit_char();
        return 8'(CH_0 + 8'($urandom_range(0, 9)));
    endfunction

    function automatic logic [7:0] ident_char();
        case ($urandom_range(0, 3))
            0: return 8'("a" + 8'($urandom_range(0, 25)));
            1: return 8'("A" + 8'($urandom_range(0, 25)));
            2: return "_";
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    task automatic send_item(logic flush, logic [7:0] ch);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_flush   <= flush;
        i_char_in <= ch;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(1'b0, s[i]);
        end
    endtask

    task automatic write_first_line(logic [23:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic end_phase();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed tokens with random content, then an optional separator.
    task automatic send_random_token();
        int         len;
        logic [7:0] ch;
        len = $urandom_range(1, 4);
        case ($urandom_range(0, 9))
            0, 1: begin
                repeat (len) send_item(1'b0, digit_char());
                if ($urandom_range(0, 1) == 1) begin
                    send_item(1'b0, CH_DOT);
                    repeat ($urandom_range(0, 3)) send_item(1'b0, digit_char());
                    if ($urandom_range(0, 3) == 0) send_item(1'b0, CH_DOT);
                end
            end
            2, 3: begin
                send_item(1'b0, ident_char());
                repeat (len) begin
                    send_item(1'b0, ($urandom_range(0, 2) != 0) ? ident_char() : digit_char());
                end
            end
            4: begin
                send_item(1'b0, CH_QUOTE);
                repeat ($urandom_range(0, 5)) begin
                    ch = 8'($urandom);
                    if (ch == CH_QUOTE || ch == CH_NL) ch = CH_SPACE;
                    send_item(1'b0, ch);
                end
                case ($urandom_range(0, 5))
                    0: send_item(1'b0, CH_NL);
                    1: send_item(1'b1, 8'($urandom));
                    default: send_item(1'b0, CH_QUOTE);
                endcase
            end
            5: send_item(1'b0, ($urandom_range(0, 5) != 0) ? op_chars[$urandom_range(0, 15)]
                                                           : CH_DOT);
            6: send_item(1'b1, 8'($urandom));
            default: send_item(1'b0, 8'($urandom));
        endcase
        case ($urandom_range(0, 6))
            0, 1: send_item(1'b0, CH_SPACE);
            2: send_item(1'b0, CH_NL);
            3: send_item(1'b0, op_chars[$urandom_range(0, 15)]);
            4: send_item(1'b0, CH_QUOTE);
            default: ;
        endcase
    endtask

    initial begin
        int target;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;

        // Directed part, line counter starting from its reset value.
        send_text("12.5. ");
        send_text(".");
        send_text("a");
        send_item(1'b0, 8'hFF);
        send_text("7\"x\n");
        send_text("\"a{ .\"");
        send_text("\"b\n");
        send_text("1.\"");
        send_item(1'b1, 8'h00);
        send_item(1'b1, 8'hFF);
        send_item(1'b0, 8'h00);
        send_text("  ");
        end_phase();

        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: write_first_line(24'h000000);
                1: write_first_line(24'hFFFFFE);
                2: write_first_line(24'hFFFFFF);
                3: write_first_line(24'($urandom));
                default: write_first_line(24'($urandom_range(1, 1000)));
            endcase
            tx_idle_on = (phase != 2 && phase != N_PHASES - 1);
            rx_idle_on <= (phase != N_PHASES - 1);
            if (phase == 0) hold_req <= hold_req + 1;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) send_random_token();
            end_phase();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("char_stream_tokenizer_test: PASS");
        end else begin
            $display("char_stream_tokenizer_test: FAIL");
        end
        $finish;
    end

endmodule

/* char_stream_tokenizer.f */
rtl/cst_pkg.sv
rtl/cst_decode.sv
rtl/cst_run_buf.sv
rtl/char_stream_tokenizer.sv
verif/char_stream_tokenizer_checker.sv
verif/char_stream_tokenizer_test.sv
